// ===== design/ptlb_pkg.sv =====
// Shared types and constants for the page translation unit.
// No dependencies; the front, back, top-level and check files import this package.
package ptlb_pkg;

    localparam int PAGE_BITS_DEF  = 12;
    localparam int VADDR_BITS_DEF = 32;
    localparam int TLB_SETS_DEF   = 64;

    localparam int KIND_W  = 2;
    localparam int ADDR_W  = 32;
    localparam int FRAME_W = 20;
    localparam int OFF_W   = 12;
    localparam int CNT_W   = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_XLATE = 2'd0,
        KIND_MAP   = 2'd1,
        KIND_UNMAP = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_EXEC
    } t_bstate;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ADDR_W-1:0]  vaddr;
        logic [FRAME_W-1:0] frame;
    } t_req;

    typedef struct packed {
        logic [FRAME_W-1:0] phys_page;
        logic [OFF_W-1:0]   page_offset;
        logic               tlb_hit;
        logic               fault;
        logic               changed;
        logic [CNT_W-1:0]   lookup_count;
        logic [CNT_W-1:0]   miss_count;
    } t_rsp;

endpackage

// ===== design/ptlb_ram.sv =====
// Generic single-port RAM with registered read data.
// Depends on nothing; used for the page store and the TLB.
module ptlb_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 2,
    parameter int AW    = 1
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_addr,
    input  logic          i_we,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/ptlb_fifo.sv =====
// Two-entry request queue between the front and back parts.
// Depends on nothing but its width parameter.
module ptlb_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

endmodule

// ===== design/ptlb_front.sv =====
// Front part: accepts requests, extracts page number and offset and works out
// the TLB set with a reciprocal multiply. Depends on ptlb_pkg.
module ptlb_front import ptlb_pkg::*; #(
    parameter int PAGE_BITS  = PAGE_BITS_DEF,
    parameter int VADDR_BITS = VADDR_BITS_DEF,
    parameter int TLB_SETS   = TLB_SETS_DEF,
    parameter int VW         = 20,
    parameter int SW         = 6,
    parameter int QW         = 2 + 20 + 6 + 12 + 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  t_req          i_req,
    output logic          o_req_stall,
    input  logic          i_clearing,
    input  logic          i_full,
    output logic          o_push,
    output logic [QW-1:0] o_push_data
);

    localparam int L  = $clog2(TLB_SETS);
    localparam int SH = VW + L;
    localparam int MW = VW + 1;
    localparam int PW = VW + MW;
    localparam int RW = VW + SW + 1;
    localparam longint unsigned RECIP_L = (64'd1 << SH) / TLB_SETS;
    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);
    localparam logic [ADDR_W-1:0] VA_MASK = ADDR_W'((64'd1 << VADDR_BITS) - 64'd1);
    localparam logic [OFF_W-1:0] OFF_MASK = OFF_W'((64'd1 << PAGE_BITS) - 64'd1);
    localparam logic [RW-1:0] SETS_R = RW'(TLB_SETS);

    logic              accept;
    logic [ADDR_W-1:0] va_m;
    logic [VW-1:0]     vpn_in;
    logic              r_a_valid;
    logic [KIND_W-1:0] r_a_kind;
    logic [VW-1:0]     r_a_vpn;
    logic [OFF_W-1:0]  r_a_off;
    logic [FRAME_W-1:0] r_a_frame;
    logic [PW-1:0]     r_a_prod;
    logic [VW-1:0]     quo;
    logic [RW-1:0]     rem;
    logic [RW-1:0]     rem_c;
    logic [SW-1:0]     set_idx;

    assign o_req_stall = i_clearing || (r_a_valid && i_full);
    assign accept      = i_req_valid && !o_req_stall;
    assign va_m        = i_req.vaddr & VA_MASK;
    assign vpn_in      = VW'(va_m >> PAGE_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (o_push) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_kind  <= i_req.kind;
            r_a_vpn   <= vpn_in;
            r_a_off   <= i_req.vaddr[OFF_W-1:0] & OFF_MASK;
            r_a_frame <= i_req.frame;
            r_a_prod  <= PW'(vpn_in) * PW'(RECIP);
        end
    end

    // The quotient estimate is at most one low, so one correction step suffices.
    always_comb begin
        quo   = VW'(r_a_prod >> SH);
        rem   = RW'(r_a_vpn) - RW'(quo) * SETS_R;
        rem_c = (rem >= SETS_R) ? (rem - SETS_R) : rem;
        set_idx = SW'(rem_c);
    end

    assign o_push      = r_a_valid && !i_full;
    assign o_push_data = {r_a_kind, r_a_vpn, set_idx, r_a_off, r_a_frame};

endmodule

// ===== design/ptlb_back.sv =====
// Back part: looks up the TLB and page store, updates them and the counters,
// and holds the response register. Depends on ptlb_pkg and ptlb_ram.
module ptlb_back import ptlb_pkg::*; #(
    parameter int TLB_SETS = TLB_SETS_DEF,
    parameter int VW       = 20,
    parameter int SW       = 6,
    parameter int QW       = 2 + 20 + 6 + 12 + 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [QW-1:0] i_data,
    output logic          o_pop,
    output logic          o_clearing,
    output logic          o_rsp_valid,
    output t_rsp          o_rsp,
    input  logic          i_rsp_stall
);

    localparam int PG_N  = 1 << VW;
    localparam int CLR_N = (PG_N > TLB_SETS) ? PG_N : TLB_SETS;
    localparam int CW    = $clog2(CLR_N);
    localparam int PDW   = 1 + FRAME_W;
    localparam int TDW   = 1 + VW + FRAME_W;

    t_kind              h_kind;
    logic [VW-1:0]      h_vpn;
    logic [SW-1:0]      h_set;
    logic [OFF_W-1:0]   h_off;
    logic [FRAME_W-1:0] h_frame;

    t_bstate            r_state, n_state;
    logic [CW-1:0]      r_clr;
    logic [CNT_W-1:0]   r_lookups, n_lookups;
    logic [CNT_W-1:0]   r_misses, n_misses;
    logic               r_out_valid;
    t_rsp               r_rsp, n_rsp;
    logic               load;
    logic               out_free;

    logic [VW-1:0]      pg_addr;
    logic               pg_we, pg_re;
    logic [PDW-1:0]     pg_wd, pg_rd;
    logic [SW-1:0]      tlb_addr;
    logic               tlb_we, tlb_re;
    logic [TDW-1:0]     tlb_wd, tlb_rd;

    logic               t_v, p_v, hit;
    logic [VW-1:0]      t_tag;
    logic [FRAME_W-1:0] t_frm, p_frm;

    assign h_kind  = t_kind'(i_data[QW-1 -: KIND_W]);
    assign h_vpn   = i_data[QW-KIND_W-1 -: VW];
    assign h_set   = i_data[QW-KIND_W-VW-1 -: SW];
    assign h_off   = i_data[FRAME_W +: OFF_W];
    assign h_frame = i_data[FRAME_W-1:0];

    assign {t_v, t_tag, t_frm} = tlb_rd;
    assign {p_v, p_frm}        = pg_rd;
    assign hit      = t_v && (t_tag == h_vpn);
    assign out_free = !r_out_valid || !i_rsp_stall;

    ptlb_ram #(.W(PDW), .DEPTH(PG_N), .AW(VW)) u_page (
        .i_clk   (i_clk),
        .i_addr  (pg_addr),
        .i_we    (pg_we),
        .i_wdata (pg_wd),
        .i_re    (pg_re),
        .o_rdata (pg_rd)
    );

    ptlb_ram #(.W(TDW), .DEPTH(TLB_SETS), .AW(SW)) u_tlb (
        .i_clk   (i_clk),
        .i_addr  (tlb_addr),
        .i_we    (tlb_we),
        .i_wdata (tlb_wd),
        .i_re    (tlb_re),
        .o_rdata (tlb_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_CLEAR;
            r_clr       <= '0;
            r_lookups   <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_lookups <= n_lookups;
            r_misses  <= n_misses;
            if (r_state == BS_CLEAR) begin
                r_clr <= r_clr + CW'(1);
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rsp <= n_rsp;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_lookups = r_lookups;
        n_misses  = r_misses;
        pg_addr   = h_vpn;
        pg_we     = 1'b0;
        pg_re     = 1'b0;
        pg_wd     = '0;
        tlb_addr  = h_set;
        tlb_we    = 1'b0;
        tlb_re    = 1'b0;
        tlb_wd    = '0;
        o_pop     = 1'b0;
        load      = 1'b0;
        n_rsp             = '0;
        n_rsp.page_offset = h_off;

        unique case (r_state)
            BS_CLEAR: begin
                // Sweep both stores once so every page reads invalid.
                pg_addr  = r_clr[VW-1:0];
                pg_we    = ({1'b0, r_clr} < (CW+1)'(PG_N));
                tlb_addr = r_clr[SW-1:0];
                tlb_we   = ({1'b0, r_clr} < (CW+1)'(TLB_SETS));
                if (r_clr == CW'(CLR_N - 1)) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (i_valid) begin
                    pg_re   = 1'b1;
                    tlb_re  = 1'b1;
                    n_state = BS_EXEC;
                end
            end
            BS_EXEC: begin
                if (out_free) begin
                    load    = 1'b1;
                    o_pop   = 1'b1;
                    n_state = BS_IDLE;
                    case (h_kind)
                        KIND_XLATE: begin
                            n_lookups = r_lookups + CNT_W'(1);
                            if (hit) begin
                                n_rsp.tlb_hit   = 1'b1;
                                n_rsp.phys_page = t_frm;
                            end else begin
                                n_misses = r_misses + CNT_W'(1);
                                if (!p_v) begin
                                    n_rsp.fault = 1'b1;
                                end else begin
                                    n_rsp.phys_page = p_frm;
                                    tlb_we = 1'b1;
                                    tlb_wd = {1'b1, h_vpn, p_frm};
                                end
                            end
                        end
                        KIND_MAP: begin
                            n_lookups       = r_lookups + CNT_W'(1);
                            n_rsp.phys_page = h_frame;
                            if (hit && (t_frm == h_frame)) begin
                                n_rsp.tlb_hit = 1'b1;
                            end else begin
                                n_misses      = r_misses + CNT_W'(1);
                                pg_we         = 1'b1;
                                pg_wd         = {1'b1, h_frame};
                                tlb_we        = 1'b1;
                                tlb_wd        = {1'b1, h_vpn, h_frame};
                                n_rsp.changed = 1'b1;
                            end
                        end
                        KIND_UNMAP: begin
                            pg_we = 1'b1;
                            pg_wd = '0;
                            if (hit) begin
                                tlb_we = 1'b1;
                                tlb_wd = {1'b0, t_tag, t_frm};
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_rsp.lookup_count = n_lookups;
                    n_rsp.miss_count   = n_misses;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    assign o_clearing  = (r_state == BS_CLEAR);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_rsp;

endmodule

// ===== design/page_translation_with_tlb_unit.sv =====
// Top level of the page translation unit with a direct-mapped TLB.
// Depends on ptlb_pkg, ptlb_front, ptlb_fifo and ptlb_back.
//
// Requests (translate, map, unmap) arrive on i_req with i_req_valid and are
// taken at an edge where o_req_stall is low. Each request gives exactly one
// response on o_rsp, held while i_rsp_stall is high.
// The front registers the request, computes the TLB set from the registered
// page number and places it in a two-entry queue. The back reads the TLB and
// the page store in its IDLE state and decides, writes and loads the response
// register in its EXEC state, which waits while a stalled response is held, so
// the back takes no new request until it is through with the last one. The
// single port of each store keeps the read and the update in separate states.
// After reset the back clears the page store and TLB, one entry per cycle,
// over max(2^(VADDR_BITS-PAGE_BITS), TLB_SETS) addresses (2^20 by default); no
// request is taken during that pass. A stalled response keeps the back from
// finishing, the queue fills, and then o_req_stall rises.
module page_translation_with_tlb_unit import ptlb_pkg::*; #(
    parameter int PAGE_BITS  = PAGE_BITS_DEF,
    parameter int VADDR_BITS = VADDR_BITS_DEF,
    parameter int TLB_SETS   = TLB_SETS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  t_req i_req,
    output logic o_req_stall,
    output logic o_rsp_valid,
    output t_rsp o_rsp,
    input  logic i_rsp_stall
);

    localparam int VW = (VADDR_BITS > PAGE_BITS) ? (VADDR_BITS - PAGE_BITS) : 1;
    localparam int SW = (TLB_SETS > 1) ? $clog2(TLB_SETS) : 1;
    localparam int QW = KIND_W + VW + SW + OFF_W + FRAME_W;

    logic          clearing;
    logic          q_full, q_push, q_pop, q_valid;
    logic [QW-1:0] q_in, q_out;

    ptlb_front #(
        .PAGE_BITS(PAGE_BITS), .VADDR_BITS(VADDR_BITS), .TLB_SETS(TLB_SETS),
        .VW(VW), .SW(SW), .QW(QW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .o_req_stall (o_req_stall),
        .i_clearing  (clearing),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_push_data (q_in)
    );

    ptlb_fifo #(.W(QW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    ptlb_back #(.TLB_SETS(TLB_SETS), .VW(VW), .SW(SW), .QW(QW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_data      (q_out),
        .o_pop       (q_pop),
        .o_clearing  (clearing),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_rsp_stall (i_rsp_stall)
    );

endmodule

// ===== design/ptlb_chk.sv =====
// Port-level checks for the page translation unit, bound to its top level.
// Depends on ptlb_pkg.
module ptlb_chk import ptlb_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input t_req i_req,
    input logic o_req_stall,
    input logic o_rsp_valid,
    input t_rsp o_rsp,
    input logic i_rsp_stall
);

    a_req_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_stall) |=> (i_req_valid && $stable(i_req)))
        else $error("stalled request changed or withdrawn");

    a_rsp_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && i_rsp_stall) |=> o_rsp_valid)
        else $error("response dropped while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid right after reset");

    a_fault_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.fault) |->
            (o_rsp.phys_page == '0) && !o_rsp.tlb_hit && !o_rsp.changed)
        else $error("fault response carries a translation");

    a_changed_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.changed) |-> !o_rsp.tlb_hit && !o_rsp.fault)
        else $error("changed map reported as hit or fault");

endmodule

bind page_translation_with_tlb_unit ptlb_chk u_ptlb_chk (.*);
